FILE: hw/rtl/sspc_pkg.sv
// Shared types, sizes and register clamps for the structured sparse row compactor.
// No dependencies; every other file refers to this package by scoped names.
package sspc_pkg;

  localparam int MaxSize     = 1024;
  localparam int MaxSegments = 1024;
  localparam int MaxGroup    = 16;

  localparam int PosW   = $clog2(MaxSize);
  localparam int SegW   = $clog2(MaxSegments);
  localparam int RigW   = $clog2(MaxGroup);
  localparam int CntW   = RigW + 1;
  localparam int SizeW  = PosW + 1;
  localparam int ElemW  = 32;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEPT_ROWS     = 8'd0,
    REG_GROUP_ROWS    = 8'd1,
    REG_SEGMENT_WIDTH = 8'd2,
    REG_MATRIX_SIZE   = 8'd3
  } reg_idx_t;

  // One element with its position, as it leaves the walker
  typedef struct packed {
    logic [ElemW-1:0] element;
    logic [PosW-1:0]  col_pos;
    logic [SegW-1:0]  seg;
    logic [RigW-1:0]  row_in_group;
    logic [PosW-1:0]  group_base;
    logic             seg_start;
    logic             first_row;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             kept;
    logic [ElemW-1:0] out_value;
    logic [PosW-1:0]  out_row;
    logic [PosW-1:0]  out_col;
    logic             index_write;
    logic [SegW-1:0]  index_col;
    logic [RigW-1:0]  index_value;
    logic             overflow;
    logic             matrix_last;
  } result_t;

  // 0 acts as 1, anything above MaxGroup acts as MaxGroup
  function automatic logic [CntW-1:0] clamp_group(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) r = CntW'(1);
    else if (v > CntW'(MaxGroup)) r = CntW'(MaxGroup);
    else r = v;
    return r;
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(MaxSize)) r = SizeW'(MaxSize);
    else r = v;
    return r;
  endfunction

endpackage

FILE: hw/rtl/sspc_walker.sv
// Row-major position walker: tracks row, column, group and segment of the next element.
// Depends on sspc_pkg.
module sspc_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic                        accept,
  input  logic [sspc_pkg::ElemW-1:0]  element_bits,
  input  logic [sspc_pkg::CntW-1:0]   k_rows,
  input  logic [sspc_pkg::CntW-1:0]   g_rows,
  input  logic [sspc_pkg::SizeW-1:0]  seg_width,
  input  logic [sspc_pkg::SizeW-1:0]  mat_size,
  output sspc_pkg::item_t             item
);

  logic [sspc_pkg::PosW-1:0] row_pos;
  logic [sspc_pkg::PosW-1:0] col_pos;
  logic [sspc_pkg::RigW-1:0] row_in_group;
  logic [sspc_pkg::PosW-1:0] group_base_row;
  logic [sspc_pkg::PosW-1:0] col_in_segment;
  logic [sspc_pkg::SegW-1:0] segment_number;

  logic col_end;
  logic row_end;
  logic seg_end;
  logic grp_end;

  assign col_end = ({1'b0, col_pos} + sspc_pkg::SizeW'(1)) >= mat_size;
  assign row_end = ({1'b0, row_pos} + sspc_pkg::SizeW'(1)) >= mat_size;
  assign seg_end = ({1'b0, col_in_segment} + sspc_pkg::SizeW'(1)) >= seg_width;
  assign grp_end = ({1'b0, row_in_group} + sspc_pkg::CntW'(1)) >= g_rows;

  always_comb begin
    item.element      = element_bits;
    item.col_pos      = col_pos;
    item.seg          = segment_number;
    item.row_in_group = row_in_group;
    item.group_base   = group_base_row;
    item.seg_start    = (col_in_segment == '0);
    item.first_row    = (row_in_group == '0);
    item.last         = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_pos        <= '0;
      col_pos        <= '0;
      row_in_group   <= '0;
      group_base_row <= '0;
      col_in_segment <= '0;
      segment_number <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_pos        <= '0;
        col_in_segment <= '0;
        segment_number <= '0;
        if (row_end) begin
          row_pos        <= '0;
          row_in_group   <= '0;
          group_base_row <= '0;
        end else begin
          row_pos <= row_pos + sspc_pkg::PosW'(1);
          if (grp_end) begin
            row_in_group   <= '0;
            group_base_row <= group_base_row + sspc_pkg::PosW'(k_rows);
          end else begin
            row_in_group <= row_in_group + sspc_pkg::RigW'(1);
          end
        end
      end else begin
        col_pos <= col_pos + sspc_pkg::PosW'(1);
        if (seg_end) begin
          col_in_segment <= '0;
          segment_number <= segment_number + sspc_pkg::SegW'(1);
        end else begin
          col_in_segment <= col_in_segment + sspc_pkg::PosW'(1);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sspc_decide.sv
// Keep decision stage: per-segment kept-count memory with read-modify-write and forwarding.
// Depends on sspc_pkg.
module sspc_decide (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       accept,
  input  sspc_pkg::item_t            item_in,
  input  logic                       advance,
  input  logic [sspc_pkg::CntW-1:0]  k_rows,
  output logic                       s1_valid,
  output sspc_pkg::result_t          result
);

  logic [sspc_pkg::CntW-1:0] count_mem [sspc_pkg::MaxSegments];

  sspc_pkg::item_t           s1;
  logic [sspc_pkg::CntW-1:0] rdata;
  logic                      fwd_hit;
  logic [sspc_pkg::CntW-1:0] fwd_cnt;
  logic                      segment_kept;
  logic [sspc_pkg::PosW-1:0] segment_dest_row;

  logic [sspc_pkg::CntW-1:0] cnt_rd;
  logic [sspc_pkg::CntW-1:0] cnt_new;
  logic                      nz;
  logic                      take;
  logic                      wr_en;
  logic [sspc_pkg::PosW-1:0] dest;
  logic                      kept_now;
  logic [sspc_pkg::PosW-1:0] dest_now;
  logic                      iw;

  always_comb begin
    if (s1.first_row) cnt_rd = '0;
    else if (fwd_hit) cnt_rd = fwd_cnt;
    else cnt_rd = rdata;
    nz       = |s1.element[sspc_pkg::ElemW-2:0];
    take     = nz && (cnt_rd < k_rows);
    cnt_new  = take ? cnt_rd + sspc_pkg::CntW'(1) : cnt_rd;
    dest     = s1.group_base + sspc_pkg::PosW'(cnt_rd);
    iw       = s1.seg_start && take;
    kept_now = s1.seg_start ? take : segment_kept;
    dest_now = iw ? dest : segment_dest_row;
    wr_en    = advance && s1.seg_start;
  end

  always_comb begin
    result.kept        = kept_now;
    result.out_value   = s1.element;
    result.out_row     = kept_now ? dest_now : '0;
    result.out_col     = s1.col_pos;
    result.index_write = iw;
    result.index_col   = iw ? s1.seg : '0;
    result.index_value = iw ? s1.row_in_group : '0;
    result.overflow    = s1.seg_start && nz && !take;
    result.matrix_last = s1.last;
  end

  // Read issues with the transfer in; a write in that same cycle returns old data,
  // so capture the written count for the following item.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata   <= count_mem[item_in.seg];
      s1      <= item_in;
      fwd_hit <= wr_en && (s1.seg == item_in.seg);
      fwd_cnt <= cnt_new;
    end
    if (wr_en) begin
      count_mem[s1.seg] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      segment_kept     <= 1'b0;
      segment_dest_row <= '0;
    end else if (wr_en) begin
      segment_kept <= take;
      if (take) begin
        segment_dest_row <= dest;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cnt_new <= sspc_pkg::CntW'(sspc_pkg::MaxGroup)))
    else $error("kept count written above group limit");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance && !accept) |=> (s1_valid && $stable(s1)))
    else $error("decision stage lost its item while held");

  a_adv_valid: assert property (@(posedge clk) disable iff (rst)
    advance |-> s1_valid)
    else $error("decision stage advanced while empty");

  a_iw_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && iw) |-> (kept_now && !result.overflow))
    else $error("index entry without a kept segment");

endmodule

FILE: hw/rtl/structured_sparse_row_compactor.sv
// Top level of the structured sparse row compactor: configuration registers,
// handshakes and output register. Depends on sspc_pkg, sspc_walker, sspc_decide.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid, in_stall, element_bits | in
//  result   | out_valid, out_stall, kept..last | out
//  config   | cfg_valid, cfg_ready, idx, data  | in
//
// One element per cycle unless results stall; a result passes the decision and output
// registers. The rate is set by the kept-count memory, read as an item comes in and
// written as it advances; the count is forwarded to a later item of the same segment.
// Reset clears positions and pipeline valids; the count memory needs no clearing.
// A stall on the result side holds the output register and the decision stage together.
module structured_sparse_row_compactor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sspc_pkg::ElemW-1:0]    element_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kept,
  output logic [sspc_pkg::ElemW-1:0]    out_value,
  output logic [sspc_pkg::PosW-1:0]     out_row,
  output logic [sspc_pkg::PosW-1:0]     out_col,
  output logic                          index_write,
  output logic [sspc_pkg::SegW-1:0]     index_col,
  output logic [sspc_pkg::RigW-1:0]     index_value,
  output logic                          overflow,
  output logic                          matrix_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sspc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sspc_pkg::CfgDatW-1:0]  cfg_data
);

  logic [sspc_pkg::CntW-1:0]  kept_rows;
  logic [sspc_pkg::CntW-1:0]  group_rows;
  logic [sspc_pkg::SizeW-1:0] segment_width;
  logic [sspc_pkg::SizeW-1:0] matrix_size;

  logic [sspc_pkg::CntW-1:0]  k_rows;
  logic [sspc_pkg::CntW-1:0]  g_rows;
  logic [sspc_pkg::SizeW-1:0] seg_width;
  logic [sspc_pkg::SizeW-1:0] mat_size;

  logic              cfg_we;
  logic              accept;
  logic              advance;
  logic              s1_valid;
  sspc_pkg::item_t   item;
  sspc_pkg::result_t result;
  sspc_pkg::result_t out_reg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_rows     <= sspc_pkg::CntW'(2);
      group_rows    <= sspc_pkg::CntW'(4);
      segment_width <= sspc_pkg::SizeW'(1);
      matrix_size   <= sspc_pkg::SizeW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sspc_pkg::REG_KEPT_ROWS:     kept_rows     <= cfg_data[sspc_pkg::CntW-1:0];
        sspc_pkg::REG_GROUP_ROWS:    group_rows    <= cfg_data[sspc_pkg::CntW-1:0];
        sspc_pkg::REG_SEGMENT_WIDTH: segment_width <= cfg_data[sspc_pkg::SizeW-1:0];
        sspc_pkg::REG_MATRIX_SIZE:   matrix_size   <= cfg_data[sspc_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign k_rows    = sspc_pkg::clamp_group(kept_rows);
  assign g_rows    = sspc_pkg::clamp_group(group_rows);
  assign seg_width = sspc_pkg::clamp_size(segment_width);
  assign mat_size  = sspc_pkg::clamp_size(matrix_size);

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  sspc_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_we),
    .accept       (accept),
    .element_bits (element_bits),
    .k_rows       (k_rows),
    .g_rows       (g_rows),
    .seg_width    (seg_width),
    .mat_size     (mat_size),
    .item         (item)
  );

  sspc_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_we),
    .accept   (accept),
    .item_in  (item),
    .advance  (advance),
    .k_rows   (k_rows),
    .s1_valid (s1_valid),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  assign kept        = out_reg.kept;
  assign out_value   = out_reg.out_value;
  assign out_row     = out_reg.out_row;
  assign out_col     = out_reg.out_col;
  assign index_write = out_reg.index_write;
  assign index_col   = out_reg.index_col;
  assign index_value = out_reg.index_value;
  assign overflow    = out_reg.overflow;
  assign matrix_last = out_reg.matrix_last;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
    else $error("result changed while stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("decision stage overwrote a waiting result");

  a_kept_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(kept && overflow))
    else $error("element both kept and dropped");

endmodule
